FILE: hw/rtl/apm_pkg.sv
// Shared types and constants of the approximate pattern matcher.
// Used by apm_cfg, apm_cell, approximate_pattern_match and the bench; depends on nothing.
package apm_pkg;

  // Pattern capacity and text position counter width
  localparam int MAX_PATTERN   = 32;
  localparam int POSITION_BITS = 32;

  // Field widths
  localparam int CHAR_W    = 8;
  localparam int DIST_W    = $clog2(MAX_PATTERN + 2);
  localparam int LEN_W     = 6;
  localparam int REG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_POS_W = 32;
  localparam int OUT_DST_W = 6;
  localparam int OUT_DATA_W = 40;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS = 3'd5;

  // Settings seen by the cell row and the output stage
  typedef struct packed {
    logic [MAX_PATTERN-1:0][CHAR_W-1:0] pattern;
    logic [DIST_W-1:0]                  row_sel;
    logic [LEN_W-1:0]                   max_errors;
  } apm_cfg_t;

  // One text character travelling down the row of cells
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] text_char;
    logic              new_text;
    logic [DIST_W-1:0] up;
    logic [DIST_W-1:0] diag;
    logic [DIST_W-1:0] sel_dist;
  } apm_token_t;

endpackage

FILE: hw/rtl/apm_cfg.sv
// Configuration registers of the approximate pattern matcher.
// Depends on apm_pkg; feeds pattern bytes, row select and threshold to the core.
module apm_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [apm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [apm_pkg::REG_W-1:0]       cfg_data,
  output apm_pkg::apm_cfg_t               cfg
);

  logic [3:0][apm_pkg::REG_W-1:0] pattern_bytes;
  logic [apm_pkg::LEN_W-1:0]      pattern_length;
  logic [apm_pkg::LEN_W-1:0]      max_errors;

  // Write one register per accepted write; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= apm_pkg::LEN_W'(1);
      max_errors     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        apm_pkg::REG_PATTERN_0:  pattern_bytes[0] <= cfg_data;
        apm_pkg::REG_PATTERN_1:  pattern_bytes[1] <= cfg_data;
        apm_pkg::REG_PATTERN_2:  pattern_bytes[2] <= cfg_data;
        apm_pkg::REG_PATTERN_3:  pattern_bytes[3] <= cfg_data;
        apm_pkg::REG_PAT_LENGTH: pattern_length   <= cfg_data[apm_pkg::LEN_W-1:0];
        apm_pkg::REG_MAX_ERRORS: max_errors       <= cfg_data[apm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Slice the pattern bytes, character 0 in the low byte of register 0
  for (genvar i = 0; i < apm_pkg::MAX_PATTERN; i++) begin : g_char
    assign cfg.pattern[i] = pattern_bytes[i / 8][(i % 8) * 8 +: 8];
  end

  // Clamp the length into 1..MAX_PATTERN to pick the reported row
  always_comb begin
    if (pattern_length == '0) begin
      cfg.row_sel = apm_pkg::DIST_W'(1);
    end else if (pattern_length > apm_pkg::LEN_W'(apm_pkg::MAX_PATTERN)) begin
      cfg.row_sel = apm_pkg::DIST_W'(apm_pkg::MAX_PATTERN);
    end else begin
      cfg.row_sel = apm_pkg::DIST_W'(pattern_length);
    end
  end

  assign cfg.max_errors = max_errors;

endmodule

FILE: hw/rtl/apm_cell.sv
// One row cell of the edit-distance column: holds the row entry and
// registers the character token for the next row. Depends on apm_pkg.
module apm_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [apm_pkg::DIST_W-1:0]    row_index,
  input  logic [apm_pkg::CHAR_W-1:0]    pattern_char,
  input  logic [apm_pkg::DIST_W-1:0]    row_sel,
  input  apm_pkg::apm_token_t           tok_in,
  output apm_pkg::apm_token_t           tok_out
);

  logic [apm_pkg::DIST_W-1:0] entry;
  logic [apm_pkg::DIST_W-1:0] old_entry;
  logic [apm_pkg::DIST_W-1:0] sub_cost;
  logic [apm_pkg::DIST_W-1:0] up_cost;
  logic [apm_pkg::DIST_W-1:0] left_cost;
  logic [apm_pkg::DIST_W-1:0] best;
  apm_pkg::apm_token_t        tok_next;

  // A new text restarts the column at entry i = i
  assign old_entry = tok_in.new_text ? row_index : entry;

  // Take the cheapest of substitute, delete and insert
  always_comb begin
    sub_cost  = tok_in.diag + apm_pkg::DIST_W'(pattern_char != tok_in.text_char);
    up_cost   = tok_in.up + apm_pkg::DIST_W'(1);
    left_cost = old_entry + apm_pkg::DIST_W'(1);
    best      = sub_cost;
    if (up_cost < best) begin
      best = up_cost;
    end
    if (left_cost < best) begin
      best = left_cost;
    end
  end

  // Build the token for the next row; capture the result at the selected row
  always_comb begin
    tok_next           = tok_in;
    tok_next.up        = best;
    tok_next.diag      = old_entry;
    tok_next.sel_dist  = (row_index == row_sel) ? best : tok_in.sel_dist;
  end

  // Hold the row entry; update it when a character passes
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= row_index;
    end else if (advance && tok_in.valid) begin
      entry <= best;
    end
  end

  // Advance the token register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out.valid <= tok_in.valid;
    end
    if (advance) begin
      tok_out.text_char <= tok_next.text_char;
      tok_out.new_text  <= tok_next.new_text;
      tok_out.up        <= tok_next.up;
      tok_out.diag      <= tok_next.diag;
      tok_out.sel_dist  <= tok_next.sel_dist;
    end
  end

endmodule

FILE: hw/rtl/approximate_pattern_match.sv
// Approximate pattern matcher (k differences): top level with config,
// cell row and output stage. Depends on apm_pkg, apm_cfg and apm_cell.
//
// Usage:
//   Write the pattern bytes, length and threshold on the cfg channel while
//   the block is idle (cfg_ready is always high). Send text characters on
//   s_tdata, with s_tuser set on the first character of a new text to
//   restart the distance column and the position count.
//   Every character gives one item on m_tdata: its 1-based position, the
//   edit distance of the whole pattern ending there, and the match flag.
//   Path: a character passes through the token register of each cell in
//   turn, then the output register; the first cell register loads at the
//   accepting edge. Throughput: one character per cycle while not stalled;
//   each cell updates its row entry as the character passes, so the next
//   character can follow directly.
//   Stall: while m_tvalid is high and m_tready low the whole row freezes and
//   s_tready drops; no item is lost or repeated.
//   Reset: pattern cleared, length 1, threshold 0, column 0..MAX_PATTERN,
//   position 0, no item in flight.
module approximate_pattern_match (
  input  logic                               clk,
  input  logic                               rst,
  // Text input
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] text_char
  input  logic [0:0]                         s_tuser,   // [0] new_text
  // Results
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [apm_pkg::OUT_DATA_W-1:0]     m_tdata,   // [31:0] end_position,
                                                        // [37:32] distance,
                                                        // [38] is_match, [39] zero
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [apm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apm_pkg::REG_W-1:0]          cfg_data
);

  localparam logic [apm_pkg::POSITION_BITS-1:0] POS_LIMIT = '1;

  apm_pkg::apm_cfg_t                cfg;
  apm_pkg::apm_token_t              tok [apm_pkg::MAX_PATTERN+1];
  logic                             advance;
  logic [apm_pkg::POSITION_BITS-1:0] position;
  logic [apm_pkg::POSITION_BITS-1:0] position_next;
  logic [apm_pkg::OUT_POS_W-1:0]    end_position;
  logic [apm_pkg::OUT_DST_W-1:0]    distance;
  logic                             is_match;

  assign cfg_ready = 1'b1;

  apm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Move the whole row when the output register is free or being drained
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // Entry token: row zero is fixed at 0
  always_comb begin
    tok[0].valid     = s_tvalid;
    tok[0].text_char = s_tdata;
    tok[0].new_text  = s_tuser[0];
    tok[0].up        = '0;
    tok[0].diag      = '0;
    tok[0].sel_dist  = '0;
  end

  // Row of cells, one per pattern character
  for (genvar k = 0; k < apm_pkg::MAX_PATTERN; k++) begin : g_cell
    apm_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .advance      (advance),
      .row_index    (apm_pkg::DIST_W'(k + 1)),
      .pattern_char (cfg.pattern[k]),
      .row_sel      (cfg.row_sel),
      .tok_in       (tok[k]),
      .tok_out      (tok[k+1])
    );
  end

  // Count positions in output order, restart on new text, saturate
  always_comb begin
    if (tok[apm_pkg::MAX_PATTERN].new_text) begin
      position_next = apm_pkg::POSITION_BITS'(1);
    end else if (position != POS_LIMIT) begin
      position_next = position + apm_pkg::POSITION_BITS'(1);
    end else begin
      position_next = position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= tok[apm_pkg::MAX_PATTERN].valid;
      if (tok[apm_pkg::MAX_PATTERN].valid) begin
        position <= position_next;
      end
    end
  end

  // Register the result fields
  always_ff @(posedge clk) begin
    if (advance && tok[apm_pkg::MAX_PATTERN].valid) begin
      if (apm_pkg::POSITION_BITS > apm_pkg::OUT_POS_W &&
          position_next > apm_pkg::POSITION_BITS'(32'hFFFF_FFFF)) begin
        end_position <= '1;
      end else begin
        end_position <= apm_pkg::OUT_POS_W'(position_next);
      end
      distance <= apm_pkg::OUT_DST_W'(tok[apm_pkg::MAX_PATTERN].sel_dist);
      is_match <= apm_pkg::LEN_W'(tok[apm_pkg::MAX_PATTERN].sel_dist) <= cfg.max_errors;
    end
  end

  assign m_tdata = {1'b0, is_match, distance, end_position};

  // The reported distance never exceeds the selected row
  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (distance <= apm_pkg::OUT_DST_W'(cfg.row_sel)))
    else $error("distance above selected pattern length");

  // Positions are 1-based
  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (end_position != '0))
    else $error("zero end position");

  // No result appears right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

FILE: tb/approximate_pattern_match_test.sv
// Self-checking bench for approximate_pattern_match: a k-differences column model
// scores every text item and each item on m_tdata is compared in order.
// Depends on apm_pkg and the approximate_pattern_match RTL.
module approximate_pattern_match_test;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int DRAIN_CYCLES   = apm_pkg::MAX_PATTERN + 8;

  // Indexes past the last register; writes there must change nothing
  localparam logic [apm_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [apm_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [31:0] end_pos;
    logic [5:0]  distance;
    logic        hit;
  } hit_report_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [7:0]                     s_tdata;    // [7:0] text_char
  logic [0:0]                     s_tuser;    // [0] new_text
  logic                           m_tvalid;
  logic                           m_tready;
  logic [apm_pkg::OUT_DATA_W-1:0] m_tdata;    // [31:0] end_position, [37:32] distance,
                                              // [38] is_match, [39] zero
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [apm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [apm_pkg::REG_W-1:0]      cfg_data;

  // Column model state and its copy of the registers
  logic [7:0]  dist_col [0:apm_pkg::MAX_PATTERN];
  logic [31:0] text_pos;
  logic [63:0] pat_reg [0:3];
  logic [5:0]  pat_len;
  logic [5:0]  err_limit;

  hit_report_t hit_reports[$];
  int          fail_count = 0;
  bit          quiet = 1'b0;

  approximate_pattern_match dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Column model
  // ---------------------------------------------------------------------------

  function automatic void clear_column();
    for (int r = 0; r <= apm_pkg::MAX_PATTERN; r++) dist_col[r] = 8'(r);
    text_pos = '0;
  endfunction

  function automatic logic [7:0] pattern_byte(input int idx);
    return pat_reg[(idx >> 3) & 3][(idx & 7) * 8 +: 8];
  endfunction

  // Rows in use: zero counts as one, anything past capacity as full
  function automatic int eff_len();
    int m;
    m = pat_len;
    if (m == 0) m = 1;
    if (m > apm_pkg::MAX_PATTERN) m = apm_pkg::MAX_PATTERN;
    return m;
  endfunction

  function automatic hit_report_t score_char(input logic [7:0] c, input logic fresh);
    hit_report_t res;
    logic [7:0]  diag;
    logic [7:0]  old;
    logic [7:0]  best;
    int          m;
    if (fresh) clear_column();
    dist_col[0] = 8'd0;
    diag = 8'd0;
    // Update every row, used or not, with unit edit costs
    for (int r = 1; r <= apm_pkg::MAX_PATTERN; r++) begin
      old  = dist_col[r];
      best = diag + ((pattern_byte(r - 1) != c) ? 8'd1 : 8'd0);
      if (dist_col[r - 1] + 8'd1 < best) best = dist_col[r - 1] + 8'd1;
      if (old + 8'd1 < best) best = old + 8'd1;
      dist_col[r] = best;
      diag = old;
    end
    if (text_pos != '1) text_pos = text_pos + 1;
    m = eff_len();
    res.end_pos  = text_pos;
    res.distance = dist_col[m][5:0];
    res.hit      = (dist_col[m] <= {2'b00, err_limit});
    return res;
  endfunction

  function automatic logic [7:0] noise_char(input bit small_alpha);
    if (small_alpha && $urandom_range(0, 4) != 0) return 8'($urandom_range(8'h61, 8'h64));
    return 8'($urandom);
  endfunction

  function automatic logic [63:0] make_word(input bit small_alpha);
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[i * 8 +: 8] = noise_char(small_alpha);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one text item, with an occasional gap before it unless quiet is set
  task automatic send_char(input logic [7:0] c, input logic nt);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= nt;
    do @(posedge clk); while (!s_tready);
    hit_reports.push_back(score_char(c, nt));
  endtask

  task automatic send_string(input string s, input bit fresh);
    for (int i = 0; i < s.len(); i++) send_char(s[i], fresh && i == 0);
  endtask

  task automatic cfg_write(input logic [apm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      apm_pkg::REG_PATTERN_0, apm_pkg::REG_PATTERN_1,
      apm_pkg::REG_PATTERN_2, apm_pkg::REG_PATTERN_3: pat_reg[idx[1:0]] = data;
      apm_pkg::REG_PAT_LENGTH:                        pat_len = data[5:0];
      apm_pkg::REG_MAX_ERRORS:                        err_limit = data[5:0];
      default: ;
    endcase
  endtask

  // Hold off until every item has come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (hit_reports.size() != 0) @(posedge clk);
  endtask

  // Write all registers once the block is idle; upper bits of the short ones are noise
  task automatic apply_settings(input logic [63:0] p0, input logic [63:0] p1,
                                input logic [63:0] p2, input logic [63:0] p3,
                                input logic [5:0] len, input logic [5:0] err);
    logic [63:0] w;
    wait_idle();
    cfg_write(apm_pkg::REG_PATTERN_0, p0);
    cfg_write(apm_pkg::REG_PATTERN_1, p1);
    cfg_write(apm_pkg::REG_PATTERN_2, p2);
    cfg_write(apm_pkg::REG_PATTERN_3, p3);
    w = {$urandom, $urandom};
    w[5:0] = len;
    cfg_write(apm_pkg::REG_PAT_LENGTH, w);
    w = {$urandom, $urandom};
    w[5:0] = err;
    cfg_write(apm_pkg::REG_MAX_ERRORS, w);
    cfg_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Noise mixed with copies of the pattern carrying random edits
  task automatic send_text(input int count, input bit small_alpha, input bit fresh);
    int         sent;
    int         pick;
    logic       nt;
    logic [7:0] c;
    sent = 0;
    nt = fresh;
    while (sent < count) begin
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 79) == 0) nt = 1'b1;
        send_char(noise_char(small_alpha), nt);
        nt = 1'b0;
        sent++;
      end else begin
        for (int i = 0; i < eff_len() && sent < count; i++) begin
          pick = $urandom_range(0, 11);
          // drop this pattern character
          if (pick == 0) continue;
          c = (pick == 1) ? noise_char(small_alpha) : pattern_byte(i);
          // insert a stray character ahead of it
          if (pick == 2) begin
            send_char(noise_char(small_alpha), nt);
            nt = 1'b0;
            sent++;
          end
          send_char(c, nt);
          nt = 1'b0;
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls and in-order check
  // ---------------------------------------------------------------------------

  initial begin : drive_ready
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    hit_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (hit_reports.size() == 0) begin
        $error("unexpected item on m_tdata: %h", m_tdata);
        fail_count++;
      end else begin
        want = hit_reports.pop_front();
        if (m_tdata[31:0] !== want.end_pos) begin
          $error("end_position expected %0d actual %0d", want.end_pos, m_tdata[31:0]);
          fail_count++;
        end
        if (m_tdata[37:32] !== want.distance) begin
          $error("distance expected %0d actual %0d", want.distance, m_tdata[37:32]);
          fail_count++;
        end
        if (m_tdata[38] !== want.hit) begin
          $error("is_match expected %0d actual %0d", want.hit, m_tdata[38]);
          fail_count++;
        end
        if (m_tdata[39] !== 1'b0) begin
          $error("pad expected 0 actual %0d", m_tdata[39]);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset state: zero pattern, length one, threshold zero
  task automatic test_reset_state();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
  endtask

  // Exact hit, substitution, deletion and insertion against "ABCD"
  task automatic test_edit_cases();
    apply_settings(64'h4847_4645_4443_4241, '0, '0, '0, 6'd4, 6'd1);
    send_string("ABCD", 1'b1);
    send_string("AXCD", 1'b1);
    send_string("ABD", 1'b1);
    send_string("ABZCD", 1'b1);
  endtask

  // Length zero, full and oversize lengths, thresholds at and past the pattern size
  task automatic test_extremes();
    apply_settings('0, '0, '0, '1, 6'd0, 6'd63);
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b0);
    apply_settings('1, '1, '1, '1, 6'd63, 6'd32);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    apply_settings('0, '0, '0, '0, 6'd32, 6'd0);
    send_char(8'h80, 1'b1);
  endtask

  // Random texts over several settings; two phases keep the column across a length change
  task automatic test_random_texts();
    apply_settings(make_word(1), make_word(1), make_word(1), make_word(1), 6'd5, 6'd1);
    send_text(180, 1'b1, 1'b1);
    apply_settings(make_word(1), make_word(1), make_word(1), make_word(1), 6'd32, 6'd0);
    send_text(180, 1'b1, 1'b1);
    apply_settings(make_word(0), make_word(0), make_word(0), make_word(0), 6'd1, 6'd0);
    send_text(180, 1'b0, 1'b1);
    apply_settings(make_word(1), make_word(0), make_word(1), make_word(0), 6'd0, 6'd2);
    send_text(180, 1'b1, 1'b1);
    apply_settings(pat_reg[0], pat_reg[1], pat_reg[2], pat_reg[3], 6'd12, 6'd3);
    send_text(180, 1'b1, 1'b0);
    apply_settings(make_word(1), make_word(1), make_word(1), make_word(1), 6'd63, 6'd32);
    send_text(180, 1'b1, 1'b1);
    apply_settings(make_word(1), make_word(1), make_word(1), make_word(1), 6'd20, 6'd63);
    send_text(180, 1'b1, 1'b0);
  endtask

  // Last stretch at full rate on both sides
  task automatic test_quiet_tail();
    apply_settings(make_word(1), make_word(1), make_word(1), make_word(1), 6'd8, 6'd2);
    quiet = 1'b1;
    send_text(200, 1'b1, 1'b1);
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    for (int i = 0; i < 4; i++) pat_reg[i] = '0;
    pat_len   = 6'd1;
    err_limit = 6'd0;
    clear_column();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_edit_cases();
    test_extremes();
    test_random_texts();
    test_quiet_tail();

    // Drain, then leave room for any stray item
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("simulation failed");
    $finish;
  end

endmodule
